[rtl/lid_pkg.sv]
// Shared types and width helpers for the line intersection point block.
`timescale 1ns / 1ps

package lid_pkg;

	// width of the cross_x and cross_y result fields
	localparam int OUT_W = 32;

	// control bits that travel with each item through the divider row
	typedef struct packed {
		logic valid;
		logic den_zero;
		logic ovf_x;
		logic ovf_y;
		logic neg_x;
		logic neg_y;
	} lid_ctl_t;

	// quotient bits kept per lane: any larger offset saturates the output anyway
	function automatic int q_width(input int cw, input int fb);
		int m;
		m = (cw - 1 + fb > OUT_W - 1) ? cw - 1 + fb : OUT_W - 1;
		return m + 1;
	endfunction

endpackage

[rtl/line_intersection_point.sv]
// Top level of the 2D line intersection point block.
//
// Input channel seg_*: one item holds the end points of segments A and B as
// signed COORD_WIDTH-bit integers; it is taken on a clock edge where
// seg_valid is high and seg_stall is low. Output channel pt_*: one item per
// input with the crossing point in fixed point (FRAC_BITS fraction bits) and
// no_point, set for parallel or coincident lines (point reads zero) or for a
// saturated coordinate.
// Throughput is one item per cycle while seg_stall is low. An item passes
// five front stages, a row of QW divider cells (one quotient bit each),
// QW = max(COORD_WIDTH + FRAC_BITS - 1, 31) + 1, then one combine/saturate
// stage and the output register.
// When pt_stall holds an item, one more item parks in a skid register; only
// then does seg_stall rise and the whole pipeline freeze in place.
// Reset (arst_n low) empties every stage, the output and the skid register.
`timescale 1ns / 1ps

module line_intersection_point #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             seg_valid,
	output logic                             seg_stall,
	input  logic signed [COORD_WIDTH-1:0]    a_start_x,
	input  logic signed [COORD_WIDTH-1:0]    a_start_y,
	input  logic signed [COORD_WIDTH-1:0]    a_end_x,
	input  logic signed [COORD_WIDTH-1:0]    a_end_y,
	input  logic signed [COORD_WIDTH-1:0]    b_start_x,
	input  logic signed [COORD_WIDTH-1:0]    b_start_y,
	input  logic signed [COORD_WIDTH-1:0]    b_end_x,
	input  logic signed [COORD_WIDTH-1:0]    b_end_y,
	output logic                             pt_valid,
	input  logic                             pt_stall,
	output logic signed [lid_pkg::OUT_W-1:0] cross_x,
	output logic signed [lid_pkg::OUT_W-1:0] cross_y,
	output logic                             no_point
);
	import lid_pkg::*;

	localparam int RW = 2 * COORD_WIDTH + 1;
	localparam int QW = q_width(COORD_WIDTH, FRAC_BITS);

	// divider row links: entry 0 comes from the front, entry k from cell k-1
	lid_ctl_t                      chn_ctl    [QW+1];
	logic signed [COORD_WIDTH-1:0] chn_base_x [QW+1];
	logic signed [COORD_WIDTH-1:0] chn_base_y [QW+1];
	logic        [RW-1:0]          chn_d      [QW+1];
	logic        [RW-1:0]          chn_rem_x  [QW+1];
	logic        [RW-1:0]          chn_rem_y  [QW+1];
	logic        [QW-1:0]          chn_nq_x   [QW+1];
	logic        [QW-1:0]          chn_nq_y   [QW+1];

	logic                    adv;
	logic                    fix_valid, fix_flag;
	logic signed [OUT_W-1:0] fix_x, fix_y;

	logic                    pt_valid_q, skd_valid_q;
	logic signed [OUT_W-1:0] cross_x_q, cross_y_q, skd_x_q, skd_y_q;
	logic                    no_point_q, skd_flag_q;
	logic                    out_free;

	// the pipeline advances as a whole unless an item is parked in the skid
	assign adv       = !skd_valid_q;
	assign seg_stall = skd_valid_q;

	lid_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.seg_valid(seg_valid),
		.a_start_x(a_start_x),
		.a_start_y(a_start_y),
		.a_end_x  (a_end_x),
		.a_end_y  (a_end_y),
		.b_start_x(b_start_x),
		.b_start_y(b_start_y),
		.b_end_x  (b_end_x),
		.b_end_y  (b_end_y),
		.ctl      (chn_ctl[0]),
		.base_x   (chn_base_x[0]),
		.base_y   (chn_base_y[0]),
		.d        (chn_d[0]),
		.rem_x    (chn_rem_x[0]),
		.rem_y    (chn_rem_y[0]),
		.nq_x     (chn_nq_x[0]),
		.nq_y     (chn_nq_y[0])
	);

	// one cell per quotient bit, most significant first
	for (genvar k = 0; k < QW; k++) begin : g_cell
		lid_div_cell #(
			.COORD_WIDTH(COORD_WIDTH),
			.FRAC_BITS  (FRAC_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.ctl        (chn_ctl[k]),
			.base_x     (chn_base_x[k]),
			.base_y     (chn_base_y[k]),
			.d          (chn_d[k]),
			.rem_x      (chn_rem_x[k]),
			.rem_y      (chn_rem_y[k]),
			.nq_x       (chn_nq_x[k]),
			.nq_y       (chn_nq_y[k]),
			.step_ctl   (chn_ctl[k+1]),
			.step_base_x(chn_base_x[k+1]),
			.step_base_y(chn_base_y[k+1]),
			.step_d     (chn_d[k+1]),
			.step_rem_x (chn_rem_x[k+1]),
			.step_rem_y (chn_rem_y[k+1]),
			.step_nq_x  (chn_nq_x[k+1]),
			.step_nq_y  (chn_nq_y[k+1])
		);
	end

	// after the last cell the shift registers hold the full quotients
	lid_fix #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_fix (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl      (chn_ctl[QW]),
		.base_x   (chn_base_x[QW]),
		.base_y   (chn_base_y[QW]),
		.q_x      (chn_nq_x[QW]),
		.q_y      (chn_nq_y[QW]),
		.res_valid(fix_valid),
		.res_x    (fix_x),
		.res_y    (fix_y),
		.res_flag (fix_flag)
	);

	// output slot can load when empty or being taken this cycle
	assign out_free = !pt_valid_q || !pt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_valid_q  <= 1'b0;
			skd_valid_q <= 1'b0;
		end else if (skd_valid_q) begin
			// drain the parked item first; pipeline is frozen meanwhile
			if (out_free) begin
				pt_valid_q  <= 1'b1;
				skd_valid_q <= 1'b0;
			end
		end else if (out_free) begin
			pt_valid_q <= fix_valid;
		end else if (fix_valid) begin
			skd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skd_valid_q) begin
				cross_x_q  <= skd_x_q;
				cross_y_q  <= skd_y_q;
				no_point_q <= skd_flag_q;
			end else begin
				cross_x_q  <= fix_x;
				cross_y_q  <= fix_y;
				no_point_q <= fix_flag;
			end
		end
		if (!skd_valid_q && !out_free) begin
			skd_x_q    <= fix_x;
			skd_y_q    <= fix_y;
			skd_flag_q <= fix_flag;
		end
	end

	assign pt_valid = pt_valid_q;
	assign cross_x  = cross_x_q;
	assign cross_y  = cross_y_q;
	assign no_point = no_point_q;

	// a parked item implies the output slot is occupied
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skd_valid_q |-> pt_valid_q)
		else $error("skid register full while output slot empty");

	// the skid fills only behind a held output item
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skd_valid_q) |-> $past(pt_valid_q && pt_stall))
		else $error("skid register filled without an output stall");

	// the skid drains only when the receiver takes the output
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(skd_valid_q) |-> $past(!pt_stall))
		else $error("skid register drained during an output stall");

endmodule

[rtl/lid_front.sv]
// Front pipeline: deltas, cross products, magnitudes and divider setup.
`timescale 1ns / 1ps

module lid_front #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 16,
	localparam int RW = 2 * COORD_WIDTH + 1,
	localparam int QW = lid_pkg::q_width(COORD_WIDTH, FRAC_BITS)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            seg_valid,
	input  logic signed [COORD_WIDTH-1:0]   a_start_x,
	input  logic signed [COORD_WIDTH-1:0]   a_start_y,
	input  logic signed [COORD_WIDTH-1:0]   a_end_x,
	input  logic signed [COORD_WIDTH-1:0]   a_end_y,
	input  logic signed [COORD_WIDTH-1:0]   b_start_x,
	input  logic signed [COORD_WIDTH-1:0]   b_start_y,
	input  logic signed [COORD_WIDTH-1:0]   b_end_x,
	input  logic signed [COORD_WIDTH-1:0]   b_end_y,
	output lid_pkg::lid_ctl_t               ctl,
	output logic signed [COORD_WIDTH-1:0]   base_x,
	output logic signed [COORD_WIDTH-1:0]   base_y,
	output logic        [RW-1:0]            d,
	output logic        [RW-1:0]            rem_x,
	output logic        [RW-1:0]            rem_y,
	output logic        [QW-1:0]            nq_x,
	output logic        [QW-1:0]            nq_y
);
	import lid_pkg::*;

	localparam int DW  = COORD_WIDTH + 1;
	localparam int PW  = 2 * DW;
	localparam int PXW = RW + COORD_WIDTH;
	localparam int NW  = PXW + FRAC_BITS;
	localparam int NXW = (NW > QW) ? NW : QW + 1;
	localparam int HW  = NXW - QW;
	localparam int CMW = (HW > RW) ? HW : RW;

	// stage 1: deltas
	logic                          v_s1;
	logic signed [DW-1:0]          ax_s1, ay_s1, bx_s1, by_s1, dx_s1, dy_s1;
	logic signed [COORD_WIDTH-1:0] bsx_s1, bsy_s1;

	// stage 2: cross products and delta magnitudes
	logic                          v_s2;
	logic signed [PW-1:0]          p_bxdy_s2, p_bydx_s2, p_byax_s2, p_bxay_s2;
	logic        [COORD_WIDTH-1:0] axm_s2, aym_s2;
	logic                          axn_s2, ayn_s2;
	logic signed [COORD_WIDTH-1:0] bsx_s2, bsy_s2;
	logic        [DW-1:0]          ax_abs, ay_abs;

	// stage 3: numerator and denominator magnitudes
	logic                          v_s3;
	logic        [RW-1:0]          num_m_s3, den_m_s3;
	logic                          num_n_s3, den_n_s3, den_z_s3;
	logic        [COORD_WIDTH-1:0] axm_s3, aym_s3;
	logic                          axn_s3, ayn_s3;
	logic signed [COORD_WIDTH-1:0] bsx_s3, bsy_s3;
	logic signed [PW:0]            num_w, den_w;
	logic        [PW:0]            num_abs, den_abs;

	// stage 4: unscaled dividends
	logic                          v_s4;
	logic        [PXW-1:0]         px_s4, py_s4;
	logic                          negx_s4, negy_s4, den_z_s4;
	logic        [RW-1:0]          d_s4;
	logic signed [COORD_WIDTH-1:0] bsx_s4, bsy_s4;

	// stage 5: divider setup
	lid_ctl_t                      ctl_s5;
	logic        [RW-1:0]          d_s5, remx_s5, remy_s5;
	logic        [QW-1:0]          nqx_s5, nqy_s5;
	logic signed [COORD_WIDTH-1:0] bsx_s5, bsy_s5;
	logic        [NXW-1:0]         nx, ny;
	logic        [HW-1:0]          hix, hiy;
	logic                          ovfx, ovfy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			ctl_s5 <= '0;
		end else if (adv) begin
			v_s1   <= seg_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			ctl_s5 <= '{valid: v_s4, den_zero: den_z_s4, ovf_x: ovfx, ovf_y: ovfy,
				neg_x: negx_s4, neg_y: negy_s4};
		end
	end

	assign ax_abs  = ax_s1[DW-1] ? -ax_s1 : ax_s1;
	assign ay_abs  = ay_s1[DW-1] ? -ay_s1 : ay_s1;

	assign num_w   = (PW+1)'(p_bxdy_s2) - (PW+1)'(p_bydx_s2);
	assign den_w   = (PW+1)'(p_byax_s2) - (PW+1)'(p_bxay_s2);
	assign num_abs = num_w[PW] ? -num_w : num_w;
	assign den_abs = den_w[PW] ? -den_w : den_w;

	// split the scaled dividend: the high part seeds the remainder
	assign nx   = NXW'(px_s4) << FRAC_BITS;
	assign ny   = NXW'(py_s4) << FRAC_BITS;
	assign hix  = nx[NXW-1:QW];
	assign hiy  = ny[NXW-1:QW];
	assign ovfx = CMW'(hix) >= CMW'(d_s4);
	assign ovfy = CMW'(hiy) >= CMW'(d_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1     <= DW'(a_end_x) - DW'(a_start_x);
			ay_s1     <= DW'(a_end_y) - DW'(a_start_y);
			bx_s1     <= DW'(b_end_x) - DW'(b_start_x);
			by_s1     <= DW'(b_end_y) - DW'(b_start_y);
			dx_s1     <= DW'(a_start_x) - DW'(b_start_x);
			dy_s1     <= DW'(a_start_y) - DW'(b_start_y);
			bsx_s1    <= a_start_x;
			bsy_s1    <= a_start_y;

			p_bxdy_s2 <= PW'(bx_s1) * PW'(dy_s1);
			p_bydx_s2 <= PW'(by_s1) * PW'(dx_s1);
			p_byax_s2 <= PW'(by_s1) * PW'(ax_s1);
			p_bxay_s2 <= PW'(bx_s1) * PW'(ay_s1);
			axm_s2    <= ax_abs[COORD_WIDTH-1:0];
			aym_s2    <= ay_abs[COORD_WIDTH-1:0];
			axn_s2    <= ax_s1[DW-1];
			ayn_s2    <= ay_s1[DW-1];
			bsx_s2    <= bsx_s1;
			bsy_s2    <= bsy_s1;

			num_m_s3  <= num_abs[RW-1:0];
			den_m_s3  <= den_abs[RW-1:0];
			num_n_s3  <= num_w[PW];
			den_n_s3  <= den_w[PW];
			den_z_s3  <= (den_w == '0);
			axm_s3    <= axm_s2;
			aym_s3    <= aym_s2;
			axn_s3    <= axn_s2;
			ayn_s3    <= ayn_s2;
			bsx_s3    <= bsx_s2;
			bsy_s3    <= bsy_s2;

			px_s4     <= PXW'(num_m_s3) * PXW'(axm_s3);
			py_s4     <= PXW'(num_m_s3) * PXW'(aym_s3);
			negx_s4   <= num_n_s3 ^ axn_s3 ^ den_n_s3;
			negy_s4   <= num_n_s3 ^ ayn_s3 ^ den_n_s3;
			den_z_s4  <= den_z_s3;
			d_s4      <= den_m_s3;
			bsx_s4    <= bsx_s3;
			bsy_s4    <= bsy_s3;

			d_s5      <= d_s4;
			remx_s5   <= ovfx ? '0 : RW'(hix);
			remy_s5   <= ovfy ? '0 : RW'(hiy);
			nqx_s5    <= nx[QW-1:0];
			nqy_s5    <= ny[QW-1:0];
			bsx_s5    <= bsx_s4;
			bsy_s5    <= bsy_s4;
		end
	end

	assign ctl    = ctl_s5;
	assign base_x = bsx_s5;
	assign base_y = bsy_s5;
	assign d      = d_s5;
	assign rem_x  = remx_s5;
	assign rem_y  = remy_s5;
	assign nq_x   = nqx_s5;
	assign nq_y   = nqy_s5;

endmodule

[rtl/lid_div_cell.sv]
// One restoring-division cell: one quotient bit per lane, registered.
`timescale 1ns / 1ps

module lid_div_cell #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 16,
	localparam int RW = 2 * COORD_WIDTH + 1,
	localparam int QW = lid_pkg::q_width(COORD_WIDTH, FRAC_BITS)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  lid_pkg::lid_ctl_t               ctl,
	input  logic signed [COORD_WIDTH-1:0]   base_x,
	input  logic signed [COORD_WIDTH-1:0]   base_y,
	input  logic        [RW-1:0]            d,
	input  logic        [RW-1:0]            rem_x,
	input  logic        [RW-1:0]            rem_y,
	input  logic        [QW-1:0]            nq_x,
	input  logic        [QW-1:0]            nq_y,
	output lid_pkg::lid_ctl_t               step_ctl,
	output logic signed [COORD_WIDTH-1:0]   step_base_x,
	output logic signed [COORD_WIDTH-1:0]   step_base_y,
	output logic        [RW-1:0]            step_d,
	output logic        [RW-1:0]            step_rem_x,
	output logic        [RW-1:0]            step_rem_y,
	output logic        [QW-1:0]            step_nq_x,
	output logic        [QW-1:0]            step_nq_y
);
	import lid_pkg::*;

	lid_ctl_t                      ctl_q;
	logic signed [COORD_WIDTH-1:0] base_x_q, base_y_q;
	logic        [RW-1:0]          d_q, rem_x_q, rem_y_q;
	logic        [QW-1:0]          nq_x_q, nq_y_q;
	logic        [RW:0]            tx, ty;
	logic                          gex, gey;

	// bring down the next dividend bit, subtract the divisor where it fits
	assign tx  = {rem_x, nq_x[QW-1]};
	assign ty  = {rem_y, nq_y[QW-1]};
	assign gex = tx >= {1'b0, d};
	assign gey = ty >= {1'b0, d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			base_x_q <= base_x;
			base_y_q <= base_y;
			d_q      <= d;
			rem_x_q  <= gex ? RW'(tx - {1'b0, d}) : RW'(tx);
			rem_y_q  <= gey ? RW'(ty - {1'b0, d}) : RW'(ty);
			nq_x_q   <= {nq_x[QW-2:0], gex};
			nq_y_q   <= {nq_y[QW-2:0], gey};
		end
	end

	assign step_ctl    = ctl_q;
	assign step_base_x = base_x_q;
	assign step_base_y = base_y_q;
	assign step_d      = d_q;
	assign step_rem_x  = rem_x_q;
	assign step_rem_y  = rem_y_q;
	assign step_nq_x   = nq_x_q;
	assign step_nq_y   = nq_y_q;

	// partial remainder stays below the divisor unless the lane overflowed
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.valid |-> (ctl_q.ovf_x || rem_x_q < d_q) && (ctl_q.ovf_y || rem_y_q < d_q))
		else $error("division remainder not below divisor");

endmodule

[rtl/lid_fix.sv]
// Final stage: sign the quotient, add the scaled start point, saturate; a zero denominator gives a zero point.
`timescale 1ns / 1ps

module lid_fix #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 16,
	localparam int QW = lid_pkg::q_width(COORD_WIDTH, FRAC_BITS)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  lid_pkg::lid_ctl_t                ctl,
	input  logic signed [COORD_WIDTH-1:0]    base_x,
	input  logic signed [COORD_WIDTH-1:0]    base_y,
	input  logic        [QW-1:0]             q_x,
	input  logic        [QW-1:0]             q_y,
	output logic                             res_valid,
	output logic signed [lid_pkg::OUT_W-1:0] res_x,
	output logic signed [lid_pkg::OUT_W-1:0] res_y,
	output logic                             res_flag
);
	import lid_pkg::*;

	localparam int BW = COORD_WIDTH + FRAC_BITS;
	localparam int SW = ((BW > QW + 1) ? BW : QW + 1) + 2;
	localparam logic signed [SW-1:0] MAXV = SW'(2 ** (OUT_W - 1) - 1);
	localparam logic signed [SW-1:0] MINV = ~MAXV;
	localparam logic signed [OUT_W-1:0] OMAX = OUT_W'(MAXV);
	localparam logic signed [OUT_W-1:0] OMIN = OUT_W'(MINV);

	function automatic logic signed [SW-1:0] lane_sum(
		input logic signed [COORD_WIDTH-1:0] base,
		input logic        [QW-1:0]          q,
		input logic                          ovf,
		input logic                          neg
	);
		logic        [QW:0]   m;
		logic signed [SW-1:0] b;
		m = ovf ? {1'b1, {QW{1'b0}}} : {1'b0, q};
		b = SW'(base) <<< FRAC_BITS;
		return neg ? b - SW'(m) : b + SW'(m);
	endfunction

	logic                    valid_q, flag_q;
	logic signed [OUT_W-1:0] x_q, y_q;
	logic signed [SW-1:0]    sx, sy;
	logic                    hx, lx, hy, ly;
	logic signed [OUT_W-1:0] cx, cy;

	assign sx = lane_sum(base_x, q_x, ctl.ovf_x, ctl.neg_x);
	assign sy = lane_sum(base_y, q_y, ctl.ovf_y, ctl.neg_y);
	assign hx = sx > MAXV;
	assign lx = sx < MINV;
	assign hy = sy > MAXV;
	assign ly = sy < MINV;

	always_comb begin
		if (ctl.den_zero) begin
			cx = '0;
			cy = '0;
		end else begin
			cx = hx ? OMAX : (lx ? OMIN : sx[OUT_W-1:0]);
			cy = hy ? OMAX : (ly ? OMIN : sy[OUT_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_q    <= cx;
			y_q    <= cy;
			flag_q <= ctl.den_zero | hx | lx | hy | ly;
		end
	end

	assign res_valid = valid_q;
	assign res_x     = x_q;
	assign res_y     = y_q;
	assign res_flag  = flag_q;

endmodule
